[src/ttuv_pkg.sv]
// Shared types and constants for the triangle tangent block.
package ttuv_pkg;

   localparam int POS_PORT_W = 32;
   localparam int TEX_PORT_W = 20;
   localparam int OUT_W      = 16;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DET1,
      ST_DET2,
      ST_DETCHK,
      ST_VEC1,
      ST_VEC2,
      ST_VST,
      ST_SQ,
      ST_SST,
      ST_RSQ,
      ST_RST,
      ST_BT1,
      ST_BT2,
      ST_BT3,
      ST_BT4,
      ST_BT5,
      ST_BT6,
      ST_COUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic                    degenerate;
   } result_type;

endpackage

[src/triangle_tangent_from_uv.sv]
// Per-triangle unit tangent from vertex positions and texture coordinates.
//
// Vertices enter one word at a time on the req_ channel in triangle order.
// A word is taken at a clock edge with req_valid high and req_stall low.
// The first two vertices of a triangle are stored and give no
// result. The third starts the computation and gives one rsp_ word: the unit
// tangent in signed Q1.OUT_FRAC_BITS and a degenerate flag (tangent zero
// when the UV determinant or the tangent vector is zero).
// The computation of the third vertex is shorter when the bit loop ends
// early. Degenerate triangles finish after the squared length. Multiplies
// and the normalize loop run through one shift and add unit: shift-add
// multiplies one bit per cycle, then one result bit per pass through states
// BT1 to BT6 in the normalize loop. req_stall is high while that runs and
// until the result is loaded into the output register. A finished word sits
// in the output register while rsp_stall is high; the next triangle's
// vertices may be taken meanwhile. Reset empties the output register, clears
// the stored vertices and expects a first vertex.
module triangle_tangent_from_uv #(
   parameter int POS_WIDTH     = 32,
   parameter int TEX_WIDTH     = 20,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ttuv_pkg::POS_PORT_W-1:0] req_pos_x,
   input  logic signed [ttuv_pkg::POS_PORT_W-1:0] req_pos_y,
   input  logic signed [ttuv_pkg::POS_PORT_W-1:0] req_pos_z,
   input  logic signed [ttuv_pkg::TEX_PORT_W-1:0] req_tex_u,
   input  logic signed [ttuv_pkg::TEX_PORT_W-1:0] req_tex_v,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ttuv_pkg::OUT_W-1:0]      rsp_tangent_x,
   output logic signed [ttuv_pkg::OUT_W-1:0]      rsp_tangent_y,
   output logic signed [ttuv_pkg::OUT_W-1:0]      rsp_tangent_z,
   output logic                                  rsp_degenerate
);
   import ttuv_pkg::*;

   localparam int EW = POS_WIDTH + 1;
   localparam int DW = TEX_WIDTH + 1;

   logic [1:0]                  phase_ff, phase_in;
   logic signed [POS_WIDTH-1:0] first_pos_ff [3];
   logic signed [POS_WIDTH-1:0] second_pos_ff [3];
   logic signed [TEX_WIDTH-1:0] first_tex_ff [2];
   logic signed [TEX_WIDTH-1:0] second_tex_ff [2];
   logic signed [POS_WIDTH-1:0] pos [3];
   logic signed [TEX_WIDTH-1:0] tex [2];
   logic signed [EW-1:0]        e1 [3];
   logic signed [EW-1:0]        e2 [3];
   logic signed [DW-1:0]        du1, dv1, du2, dv2;

   logic        accept, start, core_busy, core_done, load;
   result_type  core_res, rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   assign pos[0] = req_pos_x[POS_WIDTH-1:0];
   assign pos[1] = req_pos_y[POS_WIDTH-1:0];
   assign pos[2] = req_pos_z[POS_WIDTH-1:0];
   assign tex[0] = req_tex_u[TEX_WIDTH-1:0];
   assign tex[1] = req_tex_v[TEX_WIDTH-1:0];

   assign req_stall = core_busy;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (phase_ff == PH_THIRD);
   assign load      = core_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = EW'(second_pos_ff[i]) - EW'(first_pos_ff[i]);
         e2[i] = EW'(pos[i]) - EW'(first_pos_ff[i]);
      end
      du1 = DW'(second_tex_ff[0]) - DW'(first_tex_ff[0]);
      dv1 = DW'(second_tex_ff[1]) - DW'(first_tex_ff[1]);
      du2 = DW'(tex[0]) - DW'(first_tex_ff[0]);
      dv2 = DW'(tex[1]) - DW'(first_tex_ff[1]);
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_SECOND: phase_in = PH_THIRD;
            PH_THIRD:  phase_in = PH_FIRST;
            default:   phase_in = PH_SECOND;
         endcase
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   ttuv_core #(
      .POS_WIDTH     (POS_WIDTH),
      .TEX_WIDTH     (TEX_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .e1        (e1),
      .e2        (e2),
      .du1       (du1),
      .dv1       (dv1),
      .du2       (du2),
      .dv2       (dv2),
      .res_ready (load),
      .busy      (core_busy),
      .done      (core_done),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            first_pos_ff[i]  <= '0;
            second_pos_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            first_tex_ff[i]  <= '0;
            second_tex_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (phase_ff != PH_THIRD)) begin
            if (phase_ff == PH_SECOND) begin
               second_pos_ff <= pos;
               second_tex_ff <= tex;
            end else begin
               first_pos_ff <= pos;
               first_tex_ff <= tex;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= core_res;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tangent_x  = rsp_ff.tangent_x;
   assign rsp_tangent_y  = rsp_ff.tangent_y;
   assign rsp_tangent_z  = rsp_ff.tangent_z;
   assign rsp_degenerate = rsp_ff.degenerate;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0))
      else $error("degenerate word with nonzero tangent");

   a_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FIRST || phase_ff == PH_SECOND || phase_ff == PH_THIRD))
      else $error("vertex phase out of range");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_THIRD) |=> (core_busy && phase_ff == PH_FIRST))
      else $error("third vertex did not start the computation");

endmodule

[src/ttuv_alu.sv]
// Shared shift and add/subtract unit used by the multiply and normalize steps.
module ttuv_alu #(
   parameter int AW  = 143,
   parameter int SHW = 7
) (
   input  logic signed [AW-1:0]  base,
   input  logic signed [AW-1:0]  opnd,
   input  logic [SHW-1:0]        sh,
   input  logic                  sub,
   input  logic                  en,
   output logic signed [AW-1:0]  sum
);

   logic signed [AW-1:0] shifted;

   always_comb begin
      shifted = opnd <<< sh;
      if (!en) begin
         sum = base;
      end else if (sub) begin
         sum = base - shifted;
      end else begin
         sum = base + shifted;
      end
   end

endmodule

[src/ttuv_core.sv]
// Sequencer and datapath registers: determinant, tangent vector, length and normalize.
module ttuv_core #(
   parameter int POS_WIDTH     = 32,
   parameter int TEX_WIDTH     = 20,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [POS_WIDTH:0]     e1 [3],
   input  logic signed [POS_WIDTH:0]     e2 [3],
   input  logic signed [TEX_WIDTH:0]     du1,
   input  logic signed [TEX_WIDTH:0]     dv1,
   input  logic signed [TEX_WIDTH:0]     du2,
   input  logic signed [TEX_WIDTH:0]     dv2,
   input  logic                          res_ready,
   output logic                          busy,
   output logic                          done,
   output ttuv_pkg::result_type          result
);
   import ttuv_pkg::*;

   localparam int EW  = POS_WIDTH + 1;
   localparam int DW  = TEX_WIDTH + 1;
   localparam int VW  = EW + DW + 1;
   localparam int F   = OUT_FRAC_BITS;
   localparam int AW  = 2 * VW + 2 * F + 5;
   localparam int QW  = F + 1;
   localparam int KW  = $clog2(QW);
   localparam int IW  = $clog2(VW);
   localparam int SHW = $clog2(VW + 2 * F + 3);

   state_type state_ff, state_in;

   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [VW-1:0] vec_ff [3];
   logic signed [AW-1:0] acc_ff, s_ff, d_ff, a1_ff, u_ff;
   logic [QW-1:0]        q_ff;
   logic [KW-1:0]        k_ff;
   logic [IW-1:0]        idx_ff;
   logic [1:0]           comp_ff;
   logic                 det_neg_ff, det_zero_ff;
   result_type           res_ff;

   logic signed [AW-1:0] mul_x;
   logic signed [VW-1:0] mul_y;
   logic [IW-1:0]        mul_last_idx;
   logic                 mul_sub0;
   logic [SHW-1:0]       mul_off;
   logic                 mul_last;

   logic signed [AW-1:0] alu_base, alu_opnd, alu_sum;
   logic [SHW-1:0]       alu_sh;
   logic                 alu_sub, alu_en;

   logic                 vec_zero, degen, take, bt_stop;
   logic [OUT_W-1:0]     q_out, q_signed;

   ttuv_alu #(.AW(AW), .SHW(SHW)) u_alu (
      .base (alu_base),
      .opnd (alu_opnd),
      .sh   (alu_sh),
      .sub  (alu_sub),
      .en   (alu_en),
      .sum  (alu_sum)
   );

   assign vec_zero = (vec_ff[0] == '0) && (vec_ff[1] == '0) && (vec_ff[2] == '0);
   assign degen    = det_zero_ff || vec_zero;
   assign take     = !acc_ff[AW-1];
   assign bt_stop  = (k_ff == '0) || (take && (k_ff == KW'(F)));
   assign mul_last = (idx_ff == mul_last_idx);
   assign q_out    = OUT_W'(q_ff);
   assign q_signed = vec_ff[comp_ff][VW-1] ? (OUT_W'(0) - q_out) : q_out;

   // Multiply operand selection
   always_comb begin
      mul_x        = '0;
      mul_y        = '0;
      mul_last_idx = IW'(DW - 1);
      mul_sub0     = 1'b0;
      mul_off      = '0;
      case (state_ff)
         ST_DET1: begin
            mul_x = AW'(du1_ff);
            mul_y = VW'(dv2_ff);
         end
         ST_DET2: begin
            mul_x    = AW'(du2_ff);
            mul_y    = VW'(dv1_ff);
            mul_sub0 = 1'b1;
         end
         ST_VEC1: begin
            mul_x    = AW'(e1_ff[comp_ff]);
            mul_y    = VW'(dv2_ff);
            mul_sub0 = det_neg_ff;
         end
         ST_VEC2: begin
            mul_x    = AW'(e2_ff[comp_ff]);
            mul_y    = VW'(dv1_ff);
            mul_sub0 = !det_neg_ff;
         end
         ST_SQ: begin
            mul_x        = AW'(vec_ff[comp_ff]);
            mul_y        = vec_ff[comp_ff];
            mul_last_idx = IW'(VW - 1);
         end
         ST_RSQ: begin
            mul_x        = AW'(vec_ff[comp_ff]);
            mul_y        = vec_ff[comp_ff];
            mul_last_idx = IW'(VW - 1);
            mul_off      = SHW'(2 * F + 2);
         end
         default: begin
         end
      endcase
   end

   // Shared unit control
   always_comb begin
      alu_base = acc_ff;
      alu_opnd = mul_x;
      alu_sh   = SHW'(idx_ff) + mul_off;
      alu_sub  = mul_sub0 ^ mul_last;
      alu_en   = mul_y[idx_ff];
      case (state_ff)
         ST_BT1: begin
            alu_base = d_ff;
            alu_opnd = a1_ff;
            alu_sh   = SHW'(k_ff) + SHW'(2);
            alu_sub  = 1'b1;
            alu_en   = 1'b1;
         end
         ST_BT2: begin
            alu_opnd = s_ff;
            alu_sh   = SHW'({k_ff, 1'b0}) + SHW'(2);
            alu_sub  = 1'b1;
            alu_en   = 1'b1;
         end
         ST_BT3: begin
            alu_opnd = a1_ff;
            alu_sh   = SHW'(1);
            alu_sub  = 1'b0;
            alu_en   = 1'b1;
         end
         ST_BT4: begin
            alu_opnd = s_ff;
            alu_sh   = SHW'(k_ff) + SHW'(2);
            alu_sub  = 1'b0;
            alu_en   = 1'b1;
         end
         ST_BT5: begin
            alu_opnd = s_ff;
            alu_sh   = '0;
            alu_sub  = 1'b1;
            alu_en   = 1'b1;
         end
         ST_BT6: begin
            alu_base = a1_ff;
            alu_opnd = s_ff;
            alu_sh   = SHW'(k_ff) + SHW'(1);
            alu_sub  = 1'b0;
            alu_en   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_DET1;
         ST_DET1:   if (mul_last) state_in = ST_DET2;
         ST_DET2:   if (mul_last) state_in = ST_DETCHK;
         ST_DETCHK: state_in = ST_VEC1;
         ST_VEC1:   if (mul_last) state_in = ST_VEC2;
         ST_VEC2:   if (mul_last) state_in = ST_VST;
         ST_VST:    state_in = (comp_ff == 2'd2) ? ST_SQ : ST_VEC1;
         ST_SQ:     if (mul_last && comp_ff == 2'd2) state_in = ST_SST;
         ST_SST:    state_in = degen ? ST_DONE : ST_RSQ;
         ST_RSQ:    if (mul_last) state_in = ST_RST;
         ST_RST:    state_in = ST_BT1;
         ST_BT1:    state_in = ST_BT2;
         ST_BT2:    state_in = ST_BT3;
         ST_BT3:    state_in = ST_BT4;
         ST_BT4:    state_in = ST_BT5;
         ST_BT5:    state_in = ST_BT6;
         ST_BT6:    state_in = bt_stop ? ST_COUT : ST_BT1;
         ST_COUT:   state_in = (comp_ff == 2'd2) ? ST_DONE : ST_RSQ;
         ST_DONE:   if (res_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      busy   = (state_ff != ST_IDLE);
      done   = (state_ff == ST_DONE);
      result = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               e1_ff  <= e1;
               e2_ff  <= e2;
               du1_ff <= du1;
               dv1_ff <= dv1;
               du2_ff <= du2;
               dv2_ff <= dv2;
               acc_ff <= '0;
               idx_ff <= '0;
            end
         end
         ST_DET1, ST_DET2, ST_VEC1, ST_VEC2, ST_RSQ: begin
            acc_ff <= alu_sum;
            idx_ff <= mul_last ? '0 : idx_ff + IW'(1);
         end
         ST_SQ: begin
            acc_ff <= alu_sum;
            idx_ff <= mul_last ? '0 : idx_ff + IW'(1);
            if (mul_last) comp_ff <= comp_ff + 2'd1;
         end
         ST_DETCHK: begin
            det_neg_ff  <= acc_ff[AW-1];
            det_zero_ff <= (acc_ff == '0);
            acc_ff      <= '0;
            comp_ff     <= '0;
         end
         ST_VST: begin
            vec_ff[comp_ff] <= acc_ff[VW-1:0];
            acc_ff          <= '0;
            comp_ff         <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
         end
         ST_SST: begin
            s_ff    <= acc_ff;
            acc_ff  <= '0;
            comp_ff <= '0;
            res_ff  <= '{tangent_x: '0, tangent_y: '0, tangent_z: '0, degenerate: degen};
         end
         ST_RST: begin
            d_ff   <= acc_ff;
            a1_ff  <= '0;
            q_ff   <= '0;
            k_ff   <= KW'(F);
         end
         ST_BT1, ST_BT2, ST_BT4, ST_BT5: begin
            acc_ff <= alu_sum;
         end
         ST_BT3: begin
            // hold the updated remainder in case this bit is kept
            u_ff   <= acc_ff;
            acc_ff <= alu_sum;
         end
         ST_BT6: begin
            if (take) begin
               d_ff       <= u_ff;
               a1_ff      <= alu_sum;
               q_ff[k_ff] <= 1'b1;
            end
            if (!bt_stop) k_ff <= k_ff - KW'(1);
         end
         ST_COUT: begin
            case (comp_ff)
               2'd0:    res_ff.tangent_x <= q_signed;
               2'd1:    res_ff.tangent_y <= q_signed;
               default: res_ff.tangent_z <= q_signed;
            endcase
            acc_ff  <= '0;
            idx_ff  <= '0;
            if (comp_ff != 2'd2) comp_ff <= comp_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BT1) |-> (s_ff != '0))
      else $error("normalize loop entered with zero squared length");

   a_q_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUT && q_ff[QW-1]) |-> (q_ff[QW-2:0] == '0))
      else $error("normalized component above one");

endmodule
